>>> sv/rmf_pkg.sv
package rmf_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;

   localparam logic [7:0] END_CHAR_RESET = 8'd10;
   localparam logic [7:0] COUNT_MAX      = 8'hFF;

   localparam logic KIND_RX   = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data_byte;
      logic       last;
      logic [7:0] message_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic write_byte;
      logic empty_read;
      logic start_read;
      logic emit_byte;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic last_byte;
      logic out_free;
   } stat_type;

endpackage

>>> sv/rmf_ram.sv
module rmf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/rmf_datapath.sv
module rmf_datapath
   import rmf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [7:0] rx_byte,
   input  logic       csr_we,
   input  logic [7:0] csr_data,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PTR_W-1:0] wp_next, rp_next, rd_addr;
   logic [7:0]       cnt_ff, cnt_in;
   logic [7:0]       end_char_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [7:0]       rd_data;
   logic             full, empty, is_end, dry, ram_we, ram_re, load;
   logic [7:0]       cnt_up, cnt_down;

   assign wp_next  = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
   assign rp_next  = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;
   assign full     = (wp_next == rp_ff);
   assign empty    = (wp_ff == rp_ff);
   assign is_end   = (rd_data == end_char_ff);
   assign dry      = (rp_next == wp_ff);
   assign cnt_up   = (cnt_ff != COUNT_MAX) ? cnt_ff + 8'd1 : cnt_ff;
   assign cnt_down = (cnt_ff != 8'd0) ? cnt_ff - 8'd1 : cnt_ff;

   assign ram_we  = cmd.write_byte & ~full;
   // fetch the next byte as soon as this one is handed on
   assign ram_re  = cmd.start_read | (cmd.emit_byte & ~is_end & ~dry);
   assign rd_addr = cmd.emit_byte ? rp_next : rp_ff;
   assign load    = cmd.write_byte | cmd.empty_read | cmd.emit_byte;

   rmf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (rx_byte),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;
      if (cmd.write_byte) begin
         rsp_in.data_byte = 8'd0;
         rsp_in.last      = 1'b1;
         if (full) begin
            cnt_in         = cnt_up;
            rsp_in.status  = STATUS_OVERFLOW;
         end else begin
            wp_in         = wp_next;
            rsp_in.status = STATUS_OK;
            if (rx_byte == end_char_ff) begin
               cnt_in = cnt_up;
            end
         end
      end else if (cmd.empty_read) begin
         cnt_in           = 8'd0;
         rsp_in.status    = STATUS_EMPTY;
         rsp_in.data_byte = 8'd0;
         rsp_in.last      = 1'b1;
      end else if (cmd.emit_byte) begin
         rp_in            = rp_next;
         rsp_in.status    = STATUS_OK;
         rsp_in.data_byte = rd_data;
         rsp_in.last      = is_end | dry;
         if (is_end) begin
            cnt_in = cnt_down;
         end else if (dry) begin
            cnt_in = 8'd0;
         end
      end
      rsp_in.message_count = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= 8'd0;
         end_char_ff  <= END_CHAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
         if (csr_we) begin
            end_char_ff <= csr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.empty     = empty;
   assign stat.last_byte = is_end | dry;
   assign stat.out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

endmodule

>>> sv/rmf_ctrl.sv
module rmf_ctrl
   import rmf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_kind,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic take;

   assign req_ready = (state_ff == ST_IDLE) & stat.out_free;
   assign take      = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_kind == KIND_RX) begin
                  cmd.write_byte = 1'b1;
               end else if (stat.empty) begin
                  cmd.empty_read = 1'b1;
               end else begin
                  cmd.start_read = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_READ: begin
            // advance one byte per transfer until the delimiter or empty
            if (stat.out_free) begin
               cmd.emit_byte = 1'b1;
               if (stat.last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/rx_message_fifo_core.sv
// Channel   Ports                            Direction  Payload
// req       req_valid/req_ready/req_data     in         kind, rx_byte
// rsp       rsp_valid/rsp_ready/rsp_data     out        status, data_byte, last, message_count
// csr       csr_valid/csr_ready/csr_data     in         end_char
//
// A receive or an empty read gives a single result; with rsp_ready held high and no
// message read under way, one such item is accepted every cycle. A message read first
// fetches a byte from the registered read port of the byte RAM, then gives one byte
// per cycle while rsp_ready is high. Reset clears pointers and message count and sets
// end_char to 10; RAM contents are left as they are. A low rsp_ready holds the output
// register and stalls both the byte drain and the acceptance of new requests.
module rx_message_fifo_core
   import rmf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   rmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rmf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .rx_byte   (req_data.rx_byte),
      .csr_we    (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // no new request while a message is still being drained
   a_no_req_mid_message: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> !req_ready)
      else $error("request accepted in the middle of a message");

   a_error_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |->
      (rsp_data.last && rsp_data.data_byte == 8'd0))
      else $error("overflow or empty result is not a lone zero result");

   a_empty_clears_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_EMPTY) |-> (rsp_data.message_count == 8'd0))
      else $error("empty read left a nonzero message count");
`endif

endmodule
